>>> rtl/core/spmv_pkg.sv
// Shared types, request codes and default sizes of the CSR sparse matrix-vector unit.
`timescale 1ns / 1ps

package spmv_pkg;

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 65536;
	localparam int OUTQ_DEPTH   = 8;
	localparam int INDEX_W      = 10;
	localparam int X_DEPTH_CAP  = 1 << INDEX_W;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_NZ    = 2'd1;
	localparam logic [1:0] REQ_EMPTY = 2'd2;
	localparam logic [1:0] REQ_START = 2'd3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [INDEX_W-1:0]  index;
		logic signed [31:0]  value;
		logic                row_end;
	} req_t;

	typedef struct packed {
		logic [15:0]         row_index;
		logic signed [31:0]  row_value;
		logic                saturated;
	} res_t;

	typedef struct packed {
		logic push;
		res_t res;
	} fin_t;

endpackage

>>> rtl/core/csr_sparse_matrix_vector_multiply_unit.sv
// Top level of the streaming CSR sparse matrix times dense vector unit.
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid / req_stall  req_t: req_type, index, value, row_end
//   res       out         res_valid / res_stall  res_t: row_index, row_value, saturated
//
// One request transaction per cycle while req_stall is low; a row result passes the x
// store read, multiply, accumulate and queue write steps after the transaction that ends the row.
// req_stall rises only when queued results plus transactions in flight fill the
// 8-entry result queue, so a stalled result channel does not block requests at once.
// Reset clears the pipeline, accumulator, row counter and queue; the x store is not
// cleared and holds unknown data until loaded.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_unit import spmv_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	localparam int X_DEPTH = (MAX_COLS < X_DEPTH_CAP) ? MAX_COLS : X_DEPTH_CAP;
	localparam int X_AW    = $clog2(X_DEPTH);
	localparam int Q_AW    = $clog2(OUTQ_DEPTH);
	localparam int SW      = Q_AW + 2;

	logic               fire;
	logic               x_we;
	logic [X_AW-1:0]    x_addr;
	logic signed [31:0] x_wdata;
	logic signed [31:0] x_rdata;
	fin_t               fin;
	logic [1:0]         busy;
	logic [Q_AW:0]      q_cnt;

	assign fire      = req_valid && !req_stall;
	assign req_stall = (SW'(q_cnt) + SW'(busy)) >= SW'(OUTQ_DEPTH);

	spmv_xmem #(
		.DEPTH (X_DEPTH),
		.AW    (X_AW)
	) u_xmem (
		.clk   (clk),
		.we    (x_we),
		.waddr (x_addr),
		.wdata (x_wdata),
		.raddr (x_addr),
		.rdata (x_rdata)
	);

	spmv_mac #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.AW       (X_AW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.req     (req),
		.x_we    (x_we),
		.x_addr  (x_addr),
		.x_wdata (x_wdata),
		.x_rdata (x_rdata),
		.fin     (fin),
		.busy    (busy)
	);

	spmv_outq #(
		.DEPTH (OUTQ_DEPTH),
		.AW    (Q_AW)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin       (fin),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.count     (q_cnt)
	);

endmodule

>>> rtl/core/spmv_xmem.sv
// Dense vector store: one write port, one registered read port.
`timescale 1ns / 1ps

module spmv_xmem import spmv_pkg::*; #(
	parameter int DEPTH = MAX_COLS_DEF,
	parameter int AW    = $clog2(MAX_COLS_DEF)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata
);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/spmv_mac.sv
// Multiply-accumulate pipeline: x lookup, Q32.32 product, saturating row sum, row finish.
`timescale 1ns / 1ps

module spmv_mac import spmv_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int AW       = $clog2(MAX_COLS_DEF)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  req_t                req,
	output logic                x_we,
	output logic [AW-1:0]       x_addr,
	output logic signed [31:0]  x_wdata,
	input  logic signed [31:0]  x_rdata,
	output fin_t                fin,
	output logic [1:0]          busy
);

	localparam int ROW_LAST = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;
	localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

	logic               in_range;
	logic               vld_s1;
	logic [1:0]         type_s1;
	logic signed [31:0] val_s1;
	logic               row_end_s1;
	logic               xz_s1;
	logic signed [31:0] xv;
	logic signed [63:0] prod_c;
	logic               vld_s2;
	logic [1:0]         type_s2;
	logic               row_end_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q;
	logic               sat_q;
	logic [15:0]        row_cnt_q;
	logic [15:0]        row_nxt;
	logic signed [63:0] sum;
	logic               ovf_p;
	logic               ovf_n;
	logic signed [63:0] acc_nz;
	logic               sat_nz;
	logic signed [63:0] acc_new;
	logic               sat_new;
	logic               emit;
	logic               fin_vld_s3;
	logic signed [63:0] fin_acc_s3;
	logic               fin_sat_s3;
	logic [15:0]        fin_row_s3;
	logic               hi_clip;
	logic               lo_clip;

	assign in_range = {7'd0, req.index} < 17'(MAX_COLS);
	assign x_we     = fire && (req.req_type == REQ_LOAD) && in_range;
	assign x_addr   = req.index[AW-1:0];
	assign x_wdata  = req.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= fire;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		type_s1    <= req.req_type;
		val_s1     <= req.value;
		row_end_s1 <= req.row_end;
		xz_s1      <= !in_range;
		type_s2    <= type_s1;
		row_end_s2 <= row_end_s1;
		prod_s2    <= prod_c;
	end

	assign xv     = xz_s1 ? 32'sd0 : x_rdata;
	assign prod_c = val_s1 * xv;

	always_comb begin
		sum    = acc_q + prod_s2;
		ovf_p  = !acc_q[63] && !prod_s2[63] && sum[63];
		ovf_n  = acc_q[63] && prod_s2[63] && !sum[63];
		acc_nz = ovf_p ? ACC_MAX : (ovf_n ? ACC_MIN : sum);
		sat_nz = sat_q || ovf_p || ovf_n;
		if (type_s2 == REQ_NZ) begin
			acc_new = acc_nz;
			sat_new = sat_nz;
		end else begin
			acc_new = acc_q;
			sat_new = sat_q;
		end
		emit    = vld_s2 && (((type_s2 == REQ_NZ) && row_end_s2) || (type_s2 == REQ_EMPTY));
		row_nxt = (row_cnt_q == 16'(ROW_LAST)) ? 16'd0 : row_cnt_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			sat_q      <= 1'b0;
			row_cnt_q  <= '0;
			fin_vld_s3 <= 1'b0;
		end else begin
			fin_vld_s3 <= emit;
			if (vld_s2) begin
				case (type_s2)
					REQ_NZ: begin
						if (row_end_s2) begin
							acc_q     <= '0;
							sat_q     <= 1'b0;
							row_cnt_q <= row_nxt;
						end else begin
							acc_q <= acc_nz;
							sat_q <= sat_nz;
						end
					end
					REQ_EMPTY: begin
						acc_q     <= '0;
						sat_q     <= 1'b0;
						row_cnt_q <= row_nxt;
					end
					REQ_START: begin
						acc_q     <= '0;
						sat_q     <= 1'b0;
						row_cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_acc_s3 <= acc_new;
		fin_sat_s3 <= sat_new;
		fin_row_s3 <= row_cnt_q;
	end

	always_comb begin
		hi_clip       = !fin_acc_s3[63] && (|fin_acc_s3[62:47]);
		lo_clip       = fin_acc_s3[63] && !(&fin_acc_s3[62:47]);
		fin.push          = fin_vld_s3;
		fin.res.row_index = fin_row_s3;
		fin.res.saturated = fin_sat_s3 || hi_clip || lo_clip;
		if (hi_clip) begin
			fin.res.row_value = 32'sh7FFF_FFFF;
		end else if (lo_clip) begin
			fin.res.row_value = 32'sh8000_0000;
		end else begin
			fin.res.row_value = fin_acc_s3[47:16];
		end
	end

	assign busy = {1'b0, vld_s1} + {1'b0, vld_s2} + {1'b0, fin_vld_s3};

endmodule

>>> rtl/core/spmv_outq.sv
// Result queue between the accumulate pipeline and the result channel.
`timescale 1ns / 1ps

module spmv_outq import spmv_pkg::*; #(
	parameter int DEPTH = OUTQ_DEPTH,
	parameter int AW    = $clog2(OUTQ_DEPTH)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  fin_t         fin,
	output logic         res_valid,
	input  logic         res_stall,
	output res_t         res,
	output logic [AW:0]  count
);

	res_t          q_mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW:0]   cnt_q;
	logic          pop;

	assign pop       = res_valid && !res_stall;
	assign res_valid = cnt_q != '0;
	assign res       = q_mem[head_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (fin.push) begin
			q_mem[tail_q] <= fin.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (fin.push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			case ({fin.push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/spmv_chk.sv
// Port-level checks of the sparse matrix-vector unit, bound to its top level.
`timescale 1ns / 1ps

module spmv_chk import spmv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_stall,
	input  logic  res_valid,
	input  logic  res_stall,
	input  res_t  res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result payload changed while stalled");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled with empty result queue");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid && !req_stall)
		else $error("activity during reset");

endmodule

bind csr_sparse_matrix_vector_multiply_unit spmv_chk u_chk (.*);
